// ----- rtl/core/legv8_pkg.sv -----
package legv8_pkg;

  localparam logic [63:0] PcReset = 64'h0000_0000_0040_0000;

  // result status codes
  localparam logic [1:0] StExec = 2'd0;
  localparam logic [1:0] StHalt = 2'd1;
  localparam logic [1:0] StMem  = 2'd2;
  localparam logic [1:0] StUnk  = 2'd3;

  // opcode fields, by decode width
  localparam logic [5:0]  Op6B      = 6'h05;
  localparam logic [7:0]  Op8Cbz    = 8'hB4;
  localparam logic [7:0]  Op8Cbnz   = 8'hB5;
  localparam logic [7:0]  Op8Bcond  = 8'h54;
  localparam logic [9:0]  Op10Addi  = 10'h244;
  localparam logic [9:0]  Op10Addis = 10'h2C4;
  localparam logic [9:0]  Op10Subi  = 10'h344;
  localparam logic [9:0]  Op10Subis = 10'h3C4;
  localparam logic [9:0]  Op10Shift = 10'h34D;
  localparam logic [10:0] OpAdd   = 11'h458;
  localparam logic [10:0] OpAdds  = 11'h558;
  localparam logic [10:0] OpAnd   = 11'h450;
  localparam logic [10:0] OpAnds  = 11'h750;
  localparam logic [10:0] OpEor   = 11'h650;
  localparam logic [10:0] OpOrr   = 11'h550;
  localparam logic [10:0] OpSub   = 11'h658;
  localparam logic [10:0] OpSubs  = 11'h758;
  localparam logic [10:0] OpMovz  = 11'h694;  // +hw in the low two bits
  localparam logic [10:0] OpLdur  = 11'h7C2;
  localparam logic [10:0] OpLdurw = 11'h5C2;
  localparam logic [10:0] OpLdurb = 11'h1C2;
  localparam logic [10:0] OpLdurh = 11'h3C2;
  localparam logic [10:0] OpStur  = 11'h7C0;
  localparam logic [10:0] OpSturw = 11'h5C0;
  localparam logic [10:0] OpSturb = 11'h1C0;
  localparam logic [10:0] OpSturh = 11'h3C0;
  localparam logic [10:0] OpHlt = 11'h6A2;
  localparam logic [10:0] OpMul = 11'h4D8;
  localparam logic [10:0] OpBr  = 11'h6B0;

  // B.cond condition codes
  localparam logic [3:0] CondEq = 4'd0;
  localparam logic [3:0] CondNe = 4'd1;
  localparam logic [3:0] CondGe = 4'd10;
  localparam logic [3:0] CondLt = 4'd11;
  localparam logic [3:0] CondGt = 4'd12;
  localparam logic [3:0] CondLe = 4'd13;

  // one retired instruction, as it leaves the execute stage
  typedef struct packed {
    logic [63:0] inst_address;
    logic [63:0] next_address;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [63:0] write_value;
    logic        neg_flag;
    logic        zero_flag;
    logic        branch_taken;
  } result_t;

endpackage

// ----- rtl/core/legv8_regfile.sv -----
module legv8_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  rd_a,
  input  logic [4:0]  rd_b,
  input  logic [4:0]  rd_c,
  output logic [63:0] data_a,
  output logic [63:0] data_b,
  output logic [63:0] data_c,
  input  logic        we,
  input  logic [4:0]  wr_addr,
  input  logic [63:0] wr_data
);

  // 31 flops rows; X31 is hardwired zero
  logic [63:0] regs [0:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 31; i++) regs[i] <= '0;
    end else if (we && wr_addr != 5'd31) begin
      regs[wr_addr] <= wr_data;
    end
  end

  assign data_a = (rd_a == 5'd31) ? 64'd0 : regs[rd_a];
  assign data_b = (rd_b == 5'd31) ? 64'd0 : regs[rd_b];
  assign data_c = (rd_c == 5'd31) ? 64'd0 : regs[rd_c];

endmodule

// ----- rtl/core/legv8_exec.sv -----
module legv8_exec (
  input  logic                 instr_valid,
  input  logic [31:0]          instr,
  input  logic [63:0]          pc,
  input  logic                 halted,
  input  logic                 flag_n,
  input  logic                 flag_z,
  input  logic [63:0]          rn_val,
  input  logic [63:0]          rm_val,
  input  logic [63:0]          rt_val,
  output logic [4:0]           rn_addr,
  output logic [4:0]           rm_addr,
  output logic [4:0]           rt_addr,
  output legv8_pkg::result_t   res,
  output logic                 set_flags,
  output logic                 set_halt
);

  logic [5:0]  op6;
  logic [7:0]  op8;
  logic [9:0]  op10;
  logic [10:0] op11;
  logic [63:0] imm26, imm19, imm12, imm16, mulv;
  logic [63:0] mul_ll;
  logic [31:0] mul_lh, mul_hl;
  logic [5:0]  immr, imms;
  logic        t;

  assign op6  = instr[31:26];
  assign op8  = instr[31:24];
  assign op10 = instr[31:22];
  assign op11 = instr[31:21];
  assign rt_addr = instr[4:0];
  assign rn_addr = instr[9:5];
  assign rm_addr = instr[20:16];
  assign imm26 = {{36{instr[25]}}, instr[25:0], 2'b00};
  assign imm19 = {{43{instr[23]}}, instr[23:5], 2'b00};
  assign imm12 = {52'd0, instr[21:10]};
  assign imm16 = {48'd0, instr[20:5]};
  assign immr  = instr[21:16];
  assign imms  = instr[15:10];

  // low 64 bits of the product from 32x32 partial products
  assign mul_ll = rn_val[31:0] * rm_val[31:0];
  assign mul_lh = rn_val[31:0] * rm_val[63:32];
  assign mul_hl = rn_val[63:32] * rm_val[31:0];
  assign mulv   = mul_ll + {mul_lh + mul_hl, 32'd0};

  // condition for CB forms and B.cond
  always_comb begin
    t = 1'b0;
    if (op8 == legv8_pkg::Op8Cbz) t = (rt_val == 64'd0);
    else if (op8 == legv8_pkg::Op8Cbnz) t = (rt_val != 64'd0);
    else begin
      unique case (instr[3:0])
        legv8_pkg::CondEq: t = flag_z;
        legv8_pkg::CondNe: t = !flag_z;
        legv8_pkg::CondGe: t = !flag_n;
        legv8_pkg::CondLt: t = flag_n;
        legv8_pkg::CondGt: t = !flag_z && !flag_n;
        legv8_pkg::CondLe: t = flag_z || flag_n;
        default:           t = 1'b0;
      endcase
    end
  end

  // decode by widening opcode, then compute
  always_comb begin
    res = '0;
    res.inst_address = pc;
    res.next_address = pc + 64'd4;
    res.status = legv8_pkg::StExec;
    set_flags = 1'b0;
    set_halt  = 1'b0;
    if (halted) begin
      res.status = legv8_pkg::StHalt;
      res.next_address = pc;
    end else if (op6 == legv8_pkg::Op6B) begin
      res.next_address = pc + imm26;
      res.branch_taken = 1'b1;
    end else if (op8 == legv8_pkg::Op8Cbz || op8 == legv8_pkg::Op8Cbnz ||
                 op8 == legv8_pkg::Op8Bcond) begin
      if (t) begin
        res.next_address = pc + imm19;
        res.branch_taken = 1'b1;
      end
    end else if (op10 == legv8_pkg::Op10Addi || op10 == legv8_pkg::Op10Addis ||
                 op10 == legv8_pkg::Op10Subi || op10 == legv8_pkg::Op10Subis ||
                 op10 == legv8_pkg::Op10Shift) begin
      res.reg_written = 1'b1;
      res.dest_reg = rt_addr;
      if (op10 == legv8_pkg::Op10Addi || op10 == legv8_pkg::Op10Addis)
        res.write_value = rn_val + imm12;
      else if (op10 == legv8_pkg::Op10Subi || op10 == legv8_pkg::Op10Subis)
        res.write_value = rn_val - imm12;
      else if (imms == 6'h3F) res.write_value = rn_val >> immr;
      else res.write_value = rn_val << (6'd0 - immr);
      set_flags = (op10 == legv8_pkg::Op10Addis || op10 == legv8_pkg::Op10Subis);
    end else if (op11 == legv8_pkg::OpAdd || op11 == legv8_pkg::OpAdds ||
                 op11 == legv8_pkg::OpAnd || op11 == legv8_pkg::OpAnds ||
                 op11 == legv8_pkg::OpEor || op11 == legv8_pkg::OpOrr ||
                 op11 == legv8_pkg::OpSub || op11 == legv8_pkg::OpSubs ||
                 op11 == legv8_pkg::OpMul) begin
      res.reg_written = 1'b1;
      res.dest_reg = rt_addr;
      if (op11 == legv8_pkg::OpAdd || op11 == legv8_pkg::OpAdds)
        res.write_value = rn_val + rm_val;
      else if (op11 == legv8_pkg::OpAnd || op11 == legv8_pkg::OpAnds)
        res.write_value = rn_val & rm_val;
      else if (op11 == legv8_pkg::OpEor) res.write_value = rn_val ^ rm_val;
      else if (op11 == legv8_pkg::OpOrr) res.write_value = rn_val | rm_val;
      else if (op11 == legv8_pkg::OpSub || op11 == legv8_pkg::OpSubs)
        res.write_value = rn_val - rm_val;
      else res.write_value = mulv;
      set_flags = (op11 == legv8_pkg::OpAdds || op11 == legv8_pkg::OpAnds ||
                   op11 == legv8_pkg::OpSubs);
    end else if (op11 == legv8_pkg::OpBr) begin
      res.next_address = rn_val;
      res.branch_taken = 1'b1;
    end else if (op11 == legv8_pkg::OpLdur || op11 == legv8_pkg::OpLdurw ||
                 op11 == legv8_pkg::OpLdurb || op11 == legv8_pkg::OpLdurh ||
                 op11 == legv8_pkg::OpStur || op11 == legv8_pkg::OpSturw ||
                 op11 == legv8_pkg::OpSturb || op11 == legv8_pkg::OpSturh) begin
      res.status = legv8_pkg::StMem;
    end else if (op11[10:2] == legv8_pkg::OpMovz[10:2]) begin
      res.reg_written = 1'b1;
      res.dest_reg = rt_addr;
      res.write_value = imm16 << {op11[1:0], 4'd0};
    end else if (op11 == legv8_pkg::OpHlt) begin
      res.status = legv8_pkg::StHalt;
      set_halt = instr_valid;
    end else begin
      res.status = legv8_pkg::StUnk;
    end
    res.neg_flag  = set_flags ? res.write_value[63] : flag_n;
    res.zero_flag = set_flags ? (res.write_value == 64'd0) : flag_z;
  end

endmodule

// ----- rtl/core/legv8_subset_decode_execute.sv -----
// channel  | dir | beat fields (tdata, low bit first)
// s_axis   | in  | instr_word[31:0]
// m_axis   | out | inst_address, next_address, status, reg_written, dest_reg,
//          |     | write_value, neg_flag, zero_flag, branch_taken (+ pad)
// One instruction per cycle unless the output stalls: an accepted word
// waits in the one-word input register, then is decoded, executed and
// committed to registers, flags, PC and the output register together.
// Longest path: MUL low half, three 32x32 partial products and their sum.
// rst clears registers, flags, halt mark, and sets PC to 0x00400000.
// s_tready drops only while the output beat stalls and the input is full.
module legv8_subset_decode_execute (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,  // instr_word
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [207:0] m_tdata   // fields in table order from bit 0, zero pad
);

  logic        in_valid;
  logic [31:0] in_word;
  logic [63:0] pc;
  logic        flag_n, flag_z, halted;
  logic [4:0]  rn_addr, rm_addr, rt_addr;
  logic [63:0] rn_val, rm_val, rt_val;
  legv8_pkg::result_t res, out_res;
  logic        set_flags, set_halt, fire;

  // execute when output slot frees
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) in_word <= s_tdata;
  end

  // architectural state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= legv8_pkg::PcReset;
      flag_n <= 1'b0;
      flag_z <= 1'b0;
      halted <= 1'b0;
    end else if (fire) begin
      pc <= res.next_address;
      flag_n <= res.neg_flag;
      flag_z <= res.zero_flag;
      if (set_halt) halted <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (fire) out_res <= res;
  end

  legv8_regfile u_rf (
    .clk(clk), .rst(rst),
    .rd_a(rn_addr), .rd_b(rm_addr), .rd_c(rt_addr),
    .data_a(rn_val), .data_b(rm_val), .data_c(rt_val),
    .we(fire && res.reg_written), .wr_addr(res.dest_reg), .wr_data(res.write_value)
  );

  legv8_exec u_exec (
    .instr_valid(in_valid), .instr(in_word), .pc(pc), .halted(halted),
    .flag_n(flag_n), .flag_z(flag_z),
    .rn_val(rn_val), .rm_val(rm_val), .rt_val(rt_val),
    .rn_addr(rn_addr), .rm_addr(rm_addr), .rt_addr(rt_addr),
    .res(res), .set_flags(set_flags), .set_halt(set_halt)
  );

  assign m_tdata = {5'd0, out_res.branch_taken, out_res.zero_flag, out_res.neg_flag,
                    out_res.write_value, out_res.dest_reg, out_res.reg_written,
                    out_res.status, out_res.next_address, out_res.inst_address};

  // a halted core never moves its PC
  assert property (@(posedge clk) disable iff (rst)
    fire && halted |=> $stable(pc)) else $error("pc moved while halted");
  // flags only change on a setting instruction
  assert property (@(posedge clk) disable iff (rst)
    fire && !set_flags |=> $stable(flag_n) && $stable(flag_z))
    else $error("flags changed without S form");
  // a stalled output beat holds its payload in this design
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> !$past(fire)) else $error("fire into stalled slot");

endmodule
